/* hdl/tcf_pkg.sv */
package tcf_pkg;

	// Default build values.
	localparam int ADC_BITS_DEF = 10;
	localparam int COEFF_FRAC_DEF = 48;

	// Register file geometry: 64-bit data, one register every 8 bytes.
	localparam int COEFF_W = 48;
	localparam int DATA_W = 64;
	localparam int PADDR_W = 6;
	localparam int IDX_W = 3;
	localparam int RFIX_W = 32;

	localparam logic [IDX_W-1:0] REG_COEFF_A = 3'd0;
	localparam logic [IDX_W-1:0] REG_COEFF_B = 3'd1;
	localparam logic [IDX_W-1:0] REG_COEFF_C = 3'd2;
	localparam logic [IDX_W-1:0] REG_FIXED_R = 3'd3;
	localparam logic [IDX_W-1:0] REG_FULL_SCALE = 3'd4;

	localparam logic [COEFF_W-1:0] COEFF_A_RST = 48'd317826907003;
	localparam logic [COEFF_W-1:0] COEFF_B_RST = 48'd65900833000;
	localparam logic [COEFF_W-1:0] COEFF_C_RST = 48'd24678100;
	localparam logic [RFIX_W-1:0] FIXED_R_RST = 32'd160000;
	localparam int FULL_SCALE_RST = 1023;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	// Output format.
	localparam int TEMP_W = 19;
	localparam logic signed [TEMP_W-1:0] ABS_ZERO_F = -19'sd117676;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd131072;

	// Logarithm unit: two setup stages plus one squaring step per fraction bit.
	localparam int LOG_FRAC = 32;
	localparam int LOG_LAT = LOG_FRAC + 2;

	// Fixed-point multiplier: four stages.
	localparam int MUL_LAT = 4;
	localparam logic signed [32:0] LN2_Q32 = 33'sd2977044472;

	// Widths of the intermediate Q32 values (bounded by the input range).
	localparam int LN_W = 40;
	localparam int L2_W = 44;
	localparam int L3_W = 48;
	localparam int BL_W = 54;
	localparam int CL_W = 64;

	// Control that travels with an item through the divider and back end.
	typedef struct packed {
		logic vld;
		logic [1:0] code;
		logic neg;
	} div_side_t;

endpackage

/* hdl/tcf_mulq.sv */
// Signed a * b / 2^32, truncated toward zero. Operands up to 48 bits are split
// into 24-bit halves; the four partial products are summed in the next stage.
module tcf_mulq #(
	parameter int WA = 48,
	parameter int WB = 48,
	parameter int WR = 64
) (
	input logic clk,
	input logic signed [WA-1:0] a,
	input logic signed [WB-1:0] b,
	output logic signed [WR-1:0] p
);

	localparam int MW = 48;
	localparam int HW = MW / 2;

	logic [WA-1:0] ua;
	logic [WB-1:0] ub;
	logic [MW-1:0] ma_s1, mb_s1;
	logic sign_s1, sign_s2, sign_s3;
	logic [MW-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [2*MW-1:0] sum;
	logic [63:0] mag_s3;
	logic [WR-1:0] low;
	logic signed [WR-1:0] p_s4;

	// Magnitudes and result sign.
	always_comb begin
		ua = a[WA-1] ? (~a + 1'b1) : a;
		ub = b[WB-1] ? (~b + 1'b1) : b;
	end

	always_ff @(posedge clk) begin
		ma_s1 <= MW'(ua);
		mb_s1 <= MW'(ub);
		sign_s1 <= a[WA-1] ^ b[WB-1];
	end

	// Partial products.
	always_ff @(posedge clk) begin
		p00_s2 <= ma_s1[HW-1:0] * mb_s1[HW-1:0];
		p01_s2 <= ma_s1[HW-1:0] * mb_s1[MW-1:HW];
		p10_s2 <= ma_s1[MW-1:HW] * mb_s1[HW-1:0];
		p11_s2 <= ma_s1[MW-1:HW] * mb_s1[MW-1:HW];
		sign_s2 <= sign_s1;
	end

	// Sum and drop 32 fraction bits.
	always_comb begin
		sum = {p11_s2, {MW{1'b0}}} + ({{MW{1'b0}}, p01_s2} << HW)
			+ ({{MW{1'b0}}, p10_s2} << HW) + {{MW{1'b0}}, p00_s2};
	end

	always_ff @(posedge clk) begin
		mag_s3 <= sum[2*MW-1:32];
		sign_s3 <= sign_s2;
	end

	// Restore the sign.
	assign low = WR'(mag_s3);

	always_ff @(posedge clk) begin
		p_s4 <= sign_s3 ? (~low + 1'b1) : low;
	end

	assign p = p_s4;

endmodule

/* hdl/tcf_log2.sv */
// log2 of x (x >= 1) as an unsigned number with 32 fraction bits. The mantissa
// is normalized to Q1.31, then each stage squares it once and yields one bit.
module tcf_log2 #(
	parameter int W = 10
) (
	input logic clk,
	input logic [W-1:0] x,
	output logic [$clog2(W)+tcf_pkg::LOG_FRAC-1:0] y
);

	localparam int EW = $clog2(W);
	localparam int STEPS = tcf_pkg::LOG_FRAC;

	logic [EW-1:0] e_c, e_s1;
	logic [W-1:0] x_s1;
	logic [63:0] xw;
	logic [31:0] m_c;
	logic [31:0] m_q [STEPS+1];
	logic [STEPS-1:0] frac_q [STEPS+1];
	logic [EW-1:0] e_q [STEPS+1];

	// Position of the leading one.
	always_comb begin
		e_c = '0;
		for (int i = 1; i < W; i++) begin
			if (x[i]) begin
				e_c = EW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x;
		e_s1 <= e_c;
	end

	// Normalize to Q1.31, dropping low bits of wide values.
	always_comb begin
		xw = 64'(x_s1);
		if (32'(e_s1) >= 32'd31) begin
			m_c = 32'(xw >> (32'(e_s1) - 32'd31));
		end else begin
			m_c = 32'(xw << (32'd31 - 32'(e_s1)));
		end
	end

	always_ff @(posedge clk) begin
		m_q[0] <= m_c;
		frac_q[0] <= '0;
		e_q[0] <= e_s1;
	end

	// One squaring step per stage.
	for (genvar k = 0; k < STEPS; k++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;

		assign sq = m_q[k] * m_q[k];
		assign t = sq[63:31];

		always_ff @(posedge clk) begin
			m_q[k+1] <= t[32] ? t[32:1] : t[31:0];
			frac_q[k+1] <= {frac_q[k][STEPS-2:0], t[32]};
			e_q[k+1] <= e_q[k];
		end
	end

	assign y = {e_q[STEPS], frac_q[STEPS]};

endmodule

/* hdl/tcf_div.sv */
// Restoring division 2^QW / d, one quotient bit per stage.
module tcf_div #(
	parameter int QW = 64
) (
	input logic clk,
	input logic arst_n,
	input logic [63:0] d_in,
	input tcf_pkg::div_side_t sb_in,
	output logic [QW-1:0] q_out,
	output tcf_pkg::div_side_t sb_out
);

	logic [63:0] r_q [QW];
	logic [QW-1:0] q_q [QW];
	logic [63:0] d_q [QW];
	tcf_pkg::div_side_t sb_q [QW];

	logic [63:0] r_p [QW];
	logic [QW-1:0] q_p [QW];
	logic [63:0] d_p [QW];
	tcf_pkg::div_side_t sb_p [QW];

	// Inputs of each stage: the remainder starts at one.
	always_comb begin
		r_p[0] = 64'd1;
		q_p[0] = '0;
		d_p[0] = d_in;
		sb_p[0] = sb_in;
		for (int k = 1; k < QW; k++) begin
			r_p[k] = r_q[k-1];
			q_p[k] = q_q[k-1];
			d_p[k] = d_q[k-1];
			sb_p[k] = sb_q[k-1];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [64:0] r2;
		logic [64:0] diff;
		logic ge;

		// Shift in a zero, then subtract the divisor where it fits.
		assign r2 = {r_p[k], 1'b0};
		assign diff = r2 - {1'b0, d_p[k]};
		assign ge = r2 >= {1'b0, d_p[k]};

		always_ff @(posedge clk) begin
			r_q[k] <= ge ? diff[63:0] : r2[63:0];
			q_q[k] <= {q_p[k][QW-2:0], ge};
			d_q[k] <= d_p[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_q[k] <= '0;
			end else begin
				sb_q[k] <= sb_p[k];
			end
		end
	end

	assign q_out = q_q[QW-1];
	assign sb_out = sb_q[QW-1];

endmodule

/* hdl/thermistor_counts_to_fahrenheit.sv */
// Channel   Signals                                        Direction  Notes
// input     start, busy, adc_counts                        in/out     taken when start && !busy
// result    done, temp_fahrenheit, status                  out        done high one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata,  in/out     64-bit, register i at 8*i
//           pready
//
// One item enters per cycle; busy is always low.
// Each result passes through the 32-step logarithm, four chained multipliers and one
// divider stage per quotient bit.
// Reset clears the valid bits and restores the register reset values.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module thermistor_counts_to_fahrenheit #(
	parameter int ADC_BITS = tcf_pkg::ADC_BITS_DEF,
	parameter int COEFF_FRAC_BITS = tcf_pkg::COEFF_FRAC_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [ADC_BITS-1:0] adc_counts,
	output logic done,
	output logic signed [tcf_pkg::TEMP_W-1:0] temp_fahrenheit,
	output logic [1:0] status,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tcf_pkg::PADDR_W-1:0] paddr,
	input logic [tcf_pkg::DATA_W-1:0] pwdata,
	output logic [tcf_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int NUM_W = ADC_BITS + tcf_pkg::RFIX_W;
	localparam int EN = $clog2(NUM_W);
	localparam int EC = $clog2(ADC_BITS);
	localparam int LW = EN + 34;
	localparam int QW = COEFF_FRAC_BITS + 16;
	localparam int FDLY = tcf_pkg::LOG_LAT + 4 * tcf_pkg::MUL_LAT + 2;
	localparam int LAT = tcf_pkg::LOG_LAT + 4 * tcf_pkg::MUL_LAT + QW + 10;
	localparam logic [63:0] THRESH = (64'd1 << COEFF_FRAC_BITS) / 64'd1000000000000;
	localparam logic [40:0] T_LIM = 41'd1 << 40;
	localparam logic signed [52:0] N_OFS = 53'sd15062402560;
	localparam logic signed [52:0] N_HI = 53'sd33554431999;
	localparam logic signed [52:0] N_LO = -53'sd16777216000;
	localparam logic signed [35:0] M_OFS = 36'sd16384000;
	localparam logic [57:0] RECIP_125 = 58'd2199023256;

	typedef struct packed {
		logic vld;
		logic bad;
	} front_side_t;

	// Configuration registers.
	logic [tcf_pkg::COEFF_W-1:0] coeff_a_q, coeff_b_q, coeff_c_q;
	logic [tcf_pkg::RFIX_W-1:0] fixed_r_q;
	logic [ADC_BITS-1:0] full_scale_q;
	logic [tcf_pkg::IDX_W-1:0] idx;

	assign idx = paddr[tcf_pkg::PADDR_W-1:tcf_pkg::PADDR_W-tcf_pkg::IDX_W];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= tcf_pkg::COEFF_A_RST;
			coeff_b_q <= tcf_pkg::COEFF_B_RST;
			coeff_c_q <= tcf_pkg::COEFF_C_RST;
			fixed_r_q <= tcf_pkg::FIXED_R_RST;
			full_scale_q <= ADC_BITS'(tcf_pkg::FULL_SCALE_RST);
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				tcf_pkg::REG_COEFF_A: coeff_a_q <= pwdata[tcf_pkg::COEFF_W-1:0];
				tcf_pkg::REG_COEFF_B: coeff_b_q <= pwdata[tcf_pkg::COEFF_W-1:0];
				tcf_pkg::REG_COEFF_C: coeff_c_q <= pwdata[tcf_pkg::COEFF_W-1:0];
				tcf_pkg::REG_FIXED_R: fixed_r_q <= pwdata[tcf_pkg::RFIX_W-1:0];
				tcf_pkg::REG_FULL_SCALE: full_scale_q <= pwdata[ADC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tcf_pkg::REG_COEFF_A: prdata = tcf_pkg::DATA_W'(coeff_a_q);
			tcf_pkg::REG_COEFF_B: prdata = tcf_pkg::DATA_W'(coeff_b_q);
			tcf_pkg::REG_COEFF_C: prdata = tcf_pkg::DATA_W'(coeff_c_q);
			tcf_pkg::REG_FIXED_R: prdata = tcf_pkg::DATA_W'(fixed_r_q);
			tcf_pkg::REG_FULL_SCALE: prdata = tcf_pkg::DATA_W'(full_scale_q);
			default: prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// Stage 1: range checks and the divider's upper leg in counts.
	logic vld_s1, bad_s1, vld_s2, bad_s2;
	logic [ADC_BITS-1:0] counts_s1, diff_s1, counts_s2;
	logic [NUM_W-1:0] num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		counts_s1 <= adc_counts;
		diff_s1 <= full_scale_q - adc_counts;
		bad_s1 <= (adc_counts == '0) || (adc_counts >= full_scale_q) || (fixed_r_q == '0);
		counts_s2 <= counts_s1;
		num_s2 <= diff_s1 * fixed_r_q;
		bad_s2 <= bad_s1;
	end

	// Logarithms of the resistance numerator and of the reading.
	logic [EN+tcf_pkg::LOG_FRAC-1:0] lg_num;
	logic [EC+tcf_pkg::LOG_FRAC-1:0] lg_cnt;

	tcf_log2 #(.W(NUM_W)) u_log_num (.clk(clk), .x(num_s2), .y(lg_num));
	tcf_log2 #(.W(ADC_BITS)) u_log_cnt (.clk(clk), .x(counts_s2), .y(lg_cnt));

	// Stage 3: log2 R in ohms (the resistor is in sixteenths).
	logic signed [LW-1:0] lnraw_s3;

	always_ff @(posedge clk) begin
		lnraw_s3 <= LW'(lg_num) - LW'(lg_cnt) - (LW'(4) << 32);
	end

	// Natural log and its powers.
	logic signed [tcf_pkg::LN_W-1:0] ln;
	logic signed [tcf_pkg::LN_W-1:0] ln_d [tcf_pkg::MUL_LAT];
	logic signed [tcf_pkg::L2_W-1:0] l2;
	logic signed [tcf_pkg::L3_W-1:0] l3;
	logic signed [tcf_pkg::BL_W-1:0] bl;
	logic signed [tcf_pkg::BL_W-1:0] bl_d [2*tcf_pkg::MUL_LAT];
	logic signed [tcf_pkg::CL_W-1:0] cl3;

	tcf_mulq #(.WA(LW), .WB(33), .WR(tcf_pkg::LN_W)) u_mul_ln (
		.clk(clk), .a(lnraw_s3), .b(tcf_pkg::LN2_Q32), .p(ln)
	);
	tcf_mulq #(.WA(tcf_pkg::LN_W), .WB(tcf_pkg::LN_W), .WR(tcf_pkg::L2_W)) u_mul_l2 (
		.clk(clk), .a(ln), .b(ln), .p(l2)
	);
	tcf_mulq #(.WA(tcf_pkg::L2_W), .WB(tcf_pkg::LN_W), .WR(tcf_pkg::L3_W)) u_mul_l3 (
		.clk(clk), .a(l2), .b(ln_d[tcf_pkg::MUL_LAT-1]), .p(l3)
	);
	tcf_mulq #(.WA(tcf_pkg::COEFF_W), .WB(tcf_pkg::LN_W), .WR(tcf_pkg::BL_W)) u_mul_b (
		.clk(clk), .a(coeff_b_q), .b(ln), .p(bl)
	);
	tcf_mulq #(.WA(tcf_pkg::COEFF_W), .WB(tcf_pkg::L3_W), .WR(tcf_pkg::CL_W)) u_mul_c (
		.clk(clk), .a(coeff_c_q), .b(l3), .p(cl3)
	);

	// Align ln with l2, and the linear term with the cubic term.
	always_ff @(posedge clk) begin
		ln_d[0] <= ln;
		for (int k = 1; k < tcf_pkg::MUL_LAT; k++) begin
			ln_d[k] <= ln_d[k-1];
		end
		bl_d[0] <= bl;
		for (int k = 1; k < 2 * tcf_pkg::MUL_LAT; k++) begin
			bl_d[k] <= bl_d[k-1];
		end
	end

	// Valid and range flag follow the arithmetic up to 1/T.
	front_side_t fsb_q [FDLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FDLY; k++) begin
				fsb_q[k] <= '0;
			end
		end else begin
			fsb_q[0] <= '{vld: vld_s2, bad: bad_s2};
			for (int k = 1; k < FDLY; k++) begin
				fsb_q[k] <= fsb_q[k-1];
			end
		end
	end

	// Stage 4: 1/T.
	logic signed [63:0] invt_s4;

	always_ff @(posedge clk) begin
		invt_s4 <= 64'(signed'(coeff_a_q)) + 64'(bl_d[2*tcf_pkg::MUL_LAT-1]) + cl3;
	end

	// Stage 5: divisor magnitude and fault code.
	logic [63:0] dmag;
	logic [63:0] d_s5;
	tcf_pkg::div_side_t sb_s5, sb_div;
	logic [QW-1:0] q_div;

	assign dmag = invt_s4[63] ? (~invt_s4 + 1'b1) : invt_s4;

	always_ff @(posedge clk) begin
		d_s5 <= dmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s5 <= '0;
		end else begin
			sb_s5.vld <= fsb_q[FDLY-1].vld;
			sb_s5.code <= fsb_q[FDLY-1].bad ? tcf_pkg::ST_RANGE :
				(dmag <= THRESH) ? tcf_pkg::ST_DEGEN : tcf_pkg::ST_OK;
			sb_s5.neg <= invt_s4[63];
		end
	end

	tcf_div #(.QW(QW)) u_div (
		.clk(clk), .arst_n(arst_n), .d_in(d_s5), .sb_in(sb_s5), .q_out(q_div), .sb_out(sb_div)
	);

	// Back end: Kelvin clamp, Fahrenheit scaling, division by 128000.
	logic [40:0] tmag;
	logic signed [41:0] t16_s6;
	logic signed [52:0] n_s7;
	logic signed [52:0] nn;
	logic signed [35:0] nc_s8;
	logic sat_s8, sat_s9;
	logic [25:0] mval;
	logic signed [35:0] msum;
	logic [57:0] prod_s9;
	logic [19:0] fq;
	tcf_pkg::div_side_t sb_s6, sb_s7, sb_s8, sb_s9;
	logic done_s10;
	logic signed [tcf_pkg::TEMP_W-1:0] temp_s10;
	logic [1:0] status_s10;

	assign tmag = (q_div > QW'(T_LIM)) ? T_LIM : 41'(q_div);
	assign nn = n_s7 - N_OFS;
	assign msum = (nc_s8 >>> 10) + M_OFS;
	assign mval = msum[25:0];
	assign fq = prod_s9[57:38];

	always_ff @(posedge clk) begin
		t16_s6 <= sb_div.neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
		n_s7 <= 53'(t16_s6) * 53'sd900;
		if (nn > N_HI) begin
			nc_s8 <= 36'(N_HI);
			sat_s8 <= 1'b1;
		end else if (nn < N_LO) begin
			nc_s8 <= 36'(N_LO);
			sat_s8 <= 1'b1;
		end else begin
			nc_s8 <= 36'(nn);
			sat_s8 <= 1'b0;
		end
		prod_s9 <= 58'(mval) * RECIP_125;
		sat_s9 <= sat_s8;
		if (sb_s9.code != tcf_pkg::ST_OK) begin
			temp_s10 <= tcf_pkg::ABS_ZERO_F;
			status_s10 <= sb_s9.code;
		end else begin
			temp_s10 <= signed'(19'(fq - 20'd131072));
			status_s10 <= sat_s9 ? tcf_pkg::ST_SAT : tcf_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s6 <= '0;
			sb_s7 <= '0;
			sb_s8 <= '0;
			sb_s9 <= '0;
			done_s10 <= 1'b0;
		end else begin
			sb_s6 <= sb_div;
			sb_s7 <= sb_s6;
			sb_s8 <= sb_s7;
			sb_s9 <= sb_s8;
			done_s10 <= sb_s9.vld;
		end
	end

	assign done = done_s10;
	assign temp_fahrenheit = temp_s10;
	assign status = status_s10;

	// Every result traces back to an item taken a fixed number of cycles earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching item");

	// Faulted readings report absolute zero.
	a_fault_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == tcf_pkg::ST_RANGE || status == tcf_pkg::ST_DEGEN)
		|-> temp_fahrenheit == tcf_pkg::ABS_ZERO_F)
		else $error("fault status with a temperature other than absolute zero");

	// A saturated result sits on one of the range limits.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tcf_pkg::ST_SAT
		|-> temp_fahrenheit == tcf_pkg::TEMP_MAX || temp_fahrenheit == tcf_pkg::TEMP_MIN)
		else $error("saturation flagged off the range limits");

endmodule
